// ----- sv/reot_pkg.sv -----
`timescale 1ns / 1ps

package reot_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int BLOCKER_W   = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_RAY_START_X   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RAY_START_Z   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RAY_END_X     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RAY_END_Z     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COLLINEAR_CHK = 3'd4;

  typedef struct packed {
    logic load;
    logic mul;
    logic commit;
  } reot_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } reot_sts_t;

endpackage

// ----- sv/reot_ctrl.sv -----
`timescale 1ns / 1ps

module reot_ctrl
  import reot_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  reot_sts_t sts,
  output reot_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DEC
  } state_t;

  state_t state;
  logic   commit_ok;

  assign in_ready  = (state == ST_IDLE);
  assign commit_ok = !sts.last || sts.out_free;

  always_comb begin
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.mul    = (state == ST_MUL);
    cmd.commit = (state == ST_DEC) && commit_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DEC;
        end
        ST_DEC: begin
          if (commit_ok) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/reot_dp.sv -----
`timescale 1ns / 1ps

module reot_dp
  import reot_pkg::*;
#(
  parameter int MAX_EDGES  = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic signed [COORD_BITS-1:0] edge_ax,
  input  logic signed [COORD_BITS-1:0] edge_az,
  input  logic signed [COORD_BITS-1:0] edge_bx,
  input  logic signed [COORD_BITS-1:0] edge_bz,
  input  logic                         last_edge,
  input  reot_cmd_t                    cmd,
  output reot_sts_t                    sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         visible,
  output logic [BLOCKER_W-1:0]         first_blocker
);

  localparam int C     = COORD_BITS;
  localparam int D     = COORD_BITS + 1;
  localparam int P     = 2 * D;
  localparam int CNT_W = (MAX_EDGES > 2) ? $clog2(MAX_EDGES) : 1;
  localparam int EXT_W = (CNT_W > BLOCKER_W) ? CNT_W : BLOCKER_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EDGES - 1);

  function automatic logic in_box(
    input logic signed [C-1:0] px,
    input logic signed [C-1:0] pz,
    input logic signed [C-1:0] qx,
    input logic signed [C-1:0] qz,
    input logic signed [C-1:0] rx,
    input logic signed [C-1:0] rz
  );
    logic x_ok;
    logic z_ok;
    x_ok = ((qx <= px) || (qx <= rx)) && ((qx >= px) || (qx >= rx));
    z_ok = ((qz <= pz) || (qz <= rz)) && ((qz >= pz) || (qz >= rz));
    return x_ok && z_ok;
  endfunction

  logic signed [C-1:0] sx, sz, ex, ez;
  logic                col;

  logic signed [D-1:0] esx, esz, asx, asz, bsx, bsz, bax, baz, sax, saz, eax, eaz;
  logic                sae, sbe, ssa, ssb, sse, last;
  logic [3:0]          onseg;

  logic signed [P-1:0] p1, q1, p2, q2, p3, q3, p4, q4;

  logic                blocked_seen;
  logic [BLOCKER_W-1:0] blocker_index;
  logic [CNT_W-1:0]    edge_counter;

  logic                pos1, neg1, pos2, neg2, pos3, neg3, pos4, neg4;
  logic                crosses, col_hit, block;
  logic [EXT_W-1:0]    idx_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      sx  <= '0;
      sz  <= '0;
      ex  <= '0;
      ez  <= '0;
      col <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RAY_START_X:   sx  <= $signed(cfg_data);
        REG_RAY_START_Z:   sz  <= $signed(cfg_data);
        REG_RAY_END_X:     ex  <= $signed(cfg_data);
        REG_RAY_END_Z:     ez  <= $signed(cfg_data);
        REG_COLLINEAR_CHK: col <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      esx   <= D'(ex) - D'(sx);
      esz   <= D'(ez) - D'(sz);
      asx   <= D'(edge_ax) - D'(sx);
      asz   <= D'(edge_az) - D'(sz);
      bsx   <= D'(edge_bx) - D'(sx);
      bsz   <= D'(edge_bz) - D'(sz);
      bax   <= D'(edge_bx) - D'(edge_ax);
      baz   <= D'(edge_bz) - D'(edge_az);
      sax   <= D'(sx) - D'(edge_ax);
      saz   <= D'(sz) - D'(edge_az);
      eax   <= D'(ex) - D'(edge_ax);
      eaz   <= D'(ez) - D'(edge_az);
      sae   <= (edge_ax == ex) && (edge_az == ez);
      sbe   <= (edge_bx == ex) && (edge_bz == ez);
      ssa   <= (edge_ax == sx) && (edge_az == sz);
      ssb   <= (edge_bx == sx) && (edge_bz == sz);
      sse   <= (sx == ex) && (sz == ez);
      onseg <= {in_box(edge_ax, edge_az, ex, ez, edge_bx, edge_bz),
                in_box(edge_ax, edge_az, sx, sz, edge_bx, edge_bz),
                in_box(sx, sz, edge_bx, edge_bz, ex, ez),
                in_box(sx, sz, edge_ax, edge_az, ex, ez)};
      last  <= last_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p1 <= esx * asz;
      q1 <= esz * asx;
      p2 <= esx * bsz;
      q2 <= esz * bsx;
      p3 <= bax * saz;
      q3 <= baz * sax;
      p4 <= bax * eaz;
      q4 <= baz * eax;
    end
  end

  assign pos1 = p1 > q1;
  assign neg1 = p1 < q1;
  assign pos2 = p2 > q2;
  assign neg2 = p2 < q2;
  assign pos3 = p3 > q3;
  assign neg3 = p3 < q3;
  assign pos4 = p4 > q4;
  assign neg4 = p4 < q4;

  always_comb begin
    crosses = !ssa && !ssb &&
              ((((pos1 && neg2) || (neg1 && pos2)) && ((pos3 && neg4) || (neg3 && pos4))) ||
               (!pos1 && !neg1 && onseg[0]) ||
               (!pos2 && !neg2 && onseg[1]) ||
               (!pos3 && !neg3 && onseg[2]) ||
               (!pos4 && !neg4 && onseg[3]));
    col_hit = col && !sse && !ssa && !pos1 && !neg1;
    block   = !sae && !sbe && (crosses || col_hit);
    idx_ext = EXT_W'(edge_counter);
  end

  assign sts.last     = last;
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked_seen  <= 1'b0;
      blocker_index <= '0;
      edge_counter  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.commit && last) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        if (last) begin
          blocked_seen  <= 1'b0;
          blocker_index <= '0;
          edge_counter  <= '0;
        end else begin
          if (block && !blocked_seen) begin
            blocked_seen  <= 1'b1;
            blocker_index <= idx_ext[BLOCKER_W-1:0];
          end
          if (edge_counter < CNT_MAX) begin
            edge_counter <= edge_counter + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && last) begin
      if (blocked_seen) begin
        visible       <= 1'b0;
        first_blocker <= blocker_index;
      end else if (block) begin
        visible       <= 1'b0;
        first_blocker <= idx_ext[BLOCKER_W-1:0];
      end else begin
        visible       <= 1'b1;
        first_blocker <= '0;
      end
    end
  end

endmodule

// ----- sv/ray_edge_occlusion_test_unit.sv -----
`timescale 1ns / 1ps

// Channel  Handshake                Payload
// ------   ---------------------    -----------------------------------------
// cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
// in       in_valid / in_ready      edge_ax, edge_az, edge_bx, edge_bz, last_edge
// out      out_valid / out_ready    visible, first_blocker
//
// Each edge item steps through loading the differences, forming the eight
// orientation products, and deciding and updating the per-query state, in that order.
// A last edge waits in the decide cycle while the previous result has not been taken.
// Configuration writes are taken in every cycle. Reset is synchronous and
// clears the configuration registers, the query state and the output valid.

module ray_edge_occlusion_test_unit
  import reot_pkg::*;
#(
  parameter int MAX_EDGES  = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] edge_ax,
  input  logic signed [COORD_BITS-1:0] edge_az,
  input  logic signed [COORD_BITS-1:0] edge_bx,
  input  logic signed [COORD_BITS-1:0] edge_bz,
  input  logic                         last_edge,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         visible,
  output logic [BLOCKER_W-1:0]         first_blocker
);

  reot_cmd_t cmd;
  reot_sts_t sts;

  assign cfg_ready = 1'b1;

  reot_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  reot_dp #(
    .MAX_EDGES  (MAX_EDGES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .edge_ax       (edge_ax),
    .edge_az       (edge_az),
    .edge_bx       (edge_bx),
    .edge_bz       (edge_bz),
    .last_edge     (last_edge),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .visible       (visible),
    .first_blocker (first_blocker)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("input taken again before the item finished");

  a_visible_no_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && visible) |-> (first_blocker == '0))
    else $error("visible result carries a blocker index");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(visible) && $stable(first_blocker))
    else $error("pending result overwritten");

endmodule
